>>> src/grbf_pkg.sv
// shared types and constants of the gaussian rbf activation unit
// no dependencies; used by every module of the block
package grbf_pkg;

    // command codes of an input transaction
    localparam logic [1:0] CMD_LOAD_CENTER = 2'd0;
    localparam logic [1:0] CMD_LOAD_SPREAD = 2'd1;
    localparam logic [1:0] CMD_EVAL        = 2'd2;

    localparam int COORD_W   = 16;
    localparam int PORT_FEAT = 4;    // features carried on the ports
    localparam int MAX_OUT   = 16;   // results per sample at most
    localparam int DIST_W    = 34;   // squared distance, lsb 2^-16
    localparam int WSQ_W     = 33;   // 2*w*w, lsb 2^-16
    localparam int Q_INT     = 4;    // integer bits of the ratio
    localparam int Q_FRAC    = 30;   // fraction bits of the ratio
    localparam int XQ_W      = Q_INT + Q_FRAC;
    localparam int Y_W       = XQ_W - 4;
    localparam int ACT_W     = 16;
    localparam int X_LIMIT   = 12;
    localparam int TERMS     = 16;
    localparam int SQUARINGS = 4;

    typedef struct packed {
        logic            done;
        logic [XQ_W-1:0] quo;
    } div_res_t;

    typedef struct packed {
        logic             done;
        logic [ACT_W-1:0] act;
    } exp_res_t;

endpackage

>>> src/gaussian_rbf_activation_unit.sv
// gaussian rbf layer: center and width tables, distance sequencer, result register
// uses grbf_pkg, grbf_div and grbf_exp
//
// channel   direction  transaction
// item      in         cmd, slot, coord_0..coord_3, spread
// result    out        neuron, activation, zero_spread, last
// cfg       in         cfg_data (centers in use)
//
// per center an evaluate fetches the table row and sums the squared distance, then runs
// the divider and the exp unit and presents the result;
// a zero width, zero distance or far center skips the divider and the exp unit.
// reset is asynchronous; the tables hold no reset value and must be written before use.
// item_ready stays low while a sample is in work; a stalled result holds the sequencer.
module gaussian_rbf_activation_unit #(
    parameter int NUM_CENTERS  = 16,
    parameter int NUM_FEATURES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [3:0]  slot,
    input  logic [15:0] coord_0,
    input  logic [15:0] coord_1,
    input  logic [15:0] coord_2,
    input  logic [15:0] coord_3,
    input  logic [15:0] spread,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  neuron,
    output logic [15:0] activation,
    output logic        zero_spread,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int CIDX_W = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;
    localparam int FI_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int FC_W   = $clog2(NUM_FEATURES + 1);
    localparam int LIM    = (NUM_CENTERS < grbf_pkg::MAX_OUT) ? NUM_CENTERS
                                                              : grbf_pkg::MAX_OUT;
    localparam logic [4:0] N_LIM = 5'(LIM);
    localparam int DW = grbf_pkg::DIST_W;
    localparam int WW = grbf_pkg::WSQ_W;

    typedef logic [NUM_FEATURES-1:0][15:0] row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIST,
        ST_CHECK,
        ST_DIV,
        ST_EXP,
        ST_OUT
    } state_t;

    // tables
    row_t        ctab [NUM_CENTERS];
    logic [15:0] stab [NUM_CENTERS];
    row_t        row_rd;
    logic [15:0] spr_rd;

    state_t            state_reg;
    logic [4:0]        ciu_reg;
    logic [4:0]        n_reg;
    logic [3:0]        j_reg;
    logic [FC_W-1:0]   f_reg;
    row_t              samp_reg;
    logic [31:0]       sq_reg;
    logic [DW-1:0]     acc_reg;
    logic [WW-1:0]     wsq_reg;
    logic [15:0]       act_reg;
    logic              zf_reg;

    logic [15:0]        coords [grbf_pkg::PORT_FEAT];
    row_t               wrow;
    logic               item_acc;
    logic               slot_ok;
    logic [CIDX_W-1:0]  waddr;
    logic [CIDX_W-1:0]  raddr;
    logic [4:0]         n_eval;
    logic [FI_W-1:0]    fi;
    logic signed [16:0] fdiff;
    logic [15:0]        fmag;
    logic [31:0]        fsq;
    logic [WW+3:0]      w12;
    logic               far;
    logic               div_start;
    logic               exp_start;
    grbf_pkg::div_res_t div_res;
    grbf_pkg::exp_res_t exp_res;

    assign coords[0] = coord_0;
    assign coords[1] = coord_1;
    assign coords[2] = coord_2;
    assign coords[3] = coord_3;

    // features past the ports read as zero
    always_comb
    begin
        for (int f = 0; f < NUM_FEATURES; f++)
        begin
            if (f < grbf_pkg::PORT_FEAT)
                wrow[f] = coords[2'(f)];
            else
                wrow[f] = '0;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign cfg_ready  = 1'b1;
    assign slot_ok    = 9'(slot) < 9'(NUM_CENTERS);
    assign waddr      = CIDX_W'(slot);
    assign raddr      = CIDX_W'(j_reg);

    always_ff @(posedge clk)
    begin
        if (item_acc && cmd == grbf_pkg::CMD_LOAD_CENTER && slot_ok)
            ctab[waddr] <= wrow;
        row_rd <= ctab[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (item_acc && cmd == grbf_pkg::CMD_LOAD_SPREAD && slot_ok)
            stab[waddr] <= spread;
        spr_rd <= stab[raddr];
    end

    always_comb
    begin
        if (ciu_reg == 5'd0)
            n_eval = 5'd1;
        else if (ciu_reg > N_LIM)
            n_eval = N_LIM;
        else
            n_eval = ciu_reg;
    end

    // one feature difference squared per cycle
    always_comb
    begin
        fi    = (f_reg < FC_W'(NUM_FEATURES)) ? f_reg[FI_W-1:0] : '0;
        fdiff = 17'(signed'(samp_reg[fi])) - 17'(signed'(row_rd[fi]));
        fmag  = fdiff[16] ? 16'(-fdiff) : fdiff[15:0];
        fsq   = fmag * fmag;
        w12   = {wsq_reg, 3'b000} + {1'b0, wsq_reg, 2'b00};
        far   = (WW + 4)'(acc_reg) >= w12;
    end

    assign div_start = (state_reg == ST_CHECK) && (wsq_reg != '0) && (acc_reg != '0) && !far;
    assign exp_start = (state_reg == ST_DIV) && div_res.done;

    grbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (wsq_reg),
        .res      (div_res)
    );

    grbf_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .xq    (div_res.quo),
        .res   (exp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ciu_reg   <= 5'd1;
            n_reg     <= 5'd1;
            j_reg     <= '0;
            f_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ciu_reg <= cfg_data;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_acc && cmd == grbf_pkg::CMD_EVAL)
                    begin
                        samp_reg  <= wrow;
                        n_reg     <= n_eval;
                        j_reg     <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    f_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_DIST;
                end
                ST_DIST:
                begin
                    if (f_reg == '0)
                        wsq_reg <= {32'(spr_rd * spr_rd), 1'b0};
                    else
                        acc_reg <= acc_reg + DW'(sq_reg);
                    sq_reg <= fsq;
                    f_reg  <= f_reg + 1'b1;
                    if (f_reg == FC_W'(NUM_FEATURES))
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    zf_reg <= (wsq_reg == '0);
                    priority if (wsq_reg == '0)
                    begin
                        act_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else if (acc_reg == '0)
                    begin
                        act_reg   <= '1;
                        state_reg <= ST_OUT;
                    end
                    else if (far)
                    begin
                        act_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                        state_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    if (exp_res.done)
                    begin
                        act_reg   <= exp_res.act;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (result_ready)
                    begin
                        if (last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = (state_reg == ST_OUT);
    assign neuron       = j_reg;
    assign activation   = act_reg;
    assign zero_spread  = zf_reg;
    assign last         = (5'(j_reg) + 5'd1) == n_reg;

    // no new transaction while a sample is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("item taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_spread |-> activation == 16'd0)
        else $error("zero width gave a nonzero activation");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last |=> !result_valid && !item_ready)
        else $error("sample ended before its last center");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == ST_CHECK && !exp_res.done)
        else $error("divider started out of sequence");

endmodule

>>> src/grbf_div.sv
// restoring divider, one quotient bit per cycle: floor(dividend * 2^30 / divisor)
// expects dividend < 16 * divisor; uses grbf_pkg
module grbf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [grbf_pkg::DIST_W-1:0]   dividend,
    input  logic [grbf_pkg::WSQ_W-1:0]    divisor,
    output grbf_pkg::div_res_t            res
);

    localparam int XW = grbf_pkg::XQ_W;
    localparam int WW = grbf_pkg::WSQ_W;
    localparam int CW = $clog2(XW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [WW-1:0] rem_reg;
    logic [WW-1:0] dvs_reg;
    logic [XW-1:0] sh_reg;

    logic [WW:0]   trial;
    logic [WW:0]   diff;
    logic          ge;
    logic [WW-1:0] rem_next;
    logic [XW-1:0] sh_next;

    always_comb
    begin
        trial    = {rem_reg, sh_reg[XW-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? diff[WW-1:0] : trial[WW-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        sh_next  = {sh_reg[XW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(XW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(XW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= WW'(dividend >> grbf_pkg::Q_INT);
            dvs_reg <= divisor;
            sh_reg  <= {dividend[grbf_pkg::Q_INT-1:0], {grbf_pkg::Q_FRAC{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign res.done = done_reg;
    assign res.quo  = sh_reg;

endmodule

>>> src/grbf_exp.sv
// exp(-x) for x in q.30 below 12: taylor series of exp(-x/16), then four squarings
// one shared multiplier, division by the term index eight bits a cycle; uses grbf_pkg
module grbf_exp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grbf_pkg::XQ_W-1:0]   xq,
    output grbf_pkg::exp_res_t          res
);

    localparam int YW = grbf_pkg::Y_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIVK,
        S_ACC,
        S_SQ,
        S_RND
    } state_t;

    state_t                         state_reg;
    logic [YW-1:0]                  y_reg;
    logic [32:0]                    t_reg;
    logic signed [34:0]             sum_reg;
    logic [4:0]                     k_reg;
    logic [31:0]                    dvd_reg;
    logic [4:0]                     rk_reg;
    logic [1:0]                     dcnt_reg;
    logic [31:0]                    e_reg;
    logic [1:0]                     sq_reg;
    logic [grbf_pkg::ACT_W-1:0]     act_reg;
    logic                           done_reg;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] prod;
    logic [31:0] dvd_next;
    logic [4:0]  rk_next;
    logic [5:0]  tr;
    logic [32:0] rnd;
    logic [31:0] e_clamp;

    // shared multiplier: series term or squaring
    always_comb
    begin
        mul_a = (state_reg == S_SQ) ? {1'b0, e_reg} : t_reg;
        mul_b = (state_reg == S_SQ) ? e_reg : 32'(y_reg);
        prod  = 65'(mul_a) * 65'(mul_b);
    end

    // eight restoring steps of the small division by k
    always_comb
    begin
        tr       = '0;
        rk_next  = rk_reg;
        dvd_next = dvd_reg;
        for (int i = 0; i < 8; i++)
        begin
            tr       = {rk_next, dvd_next[31]};
            dvd_next = {dvd_next[30:0], 1'b0};
            if (tr >= {1'b0, k_reg})
            begin
                rk_next     = 5'(tr - {1'b0, k_reg});
                dvd_next[0] = 1'b1;
            end
            else
            begin
                rk_next = tr[4:0];
            end
        end
    end

    always_comb
    begin
        if (sum_reg < 0)
            e_clamp = '0;
        else if (sum_reg[34:32] != 3'b000)
            e_clamp = '1;
        else
            e_clamp = sum_reg[31:0];
        rnd = {1'b0, e_reg} + 33'h8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_RND);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_DIVK;
                S_DIVK:
                begin
                    if (dcnt_reg == 2'd3)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (k_reg == 5'(grbf_pkg::TERMS))
                        state_reg <= S_SQ;
                    else
                        state_reg <= S_MUL;
                end
                S_SQ:
                begin
                    if (sq_reg == 2'(grbf_pkg::SQUARINGS - 1))
                        state_reg <= S_RND;
                end
                S_RND:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                y_reg   <= xq[grbf_pkg::XQ_W-1:4];
                t_reg   <= 33'h1_0000_0000;
                sum_reg <= 35'sh1_0000_0000;
                k_reg   <= 5'd1;
            end
            S_MUL:
            begin
                dvd_reg  <= prod[61:30];
                rk_reg   <= '0;
                dcnt_reg <= '0;
            end
            S_DIVK:
            begin
                dvd_reg  <= dvd_next;
                rk_reg   <= rk_next;
                dcnt_reg <= dcnt_reg + 2'd1;
                if (dcnt_reg == 2'd3)
                    t_reg <= {1'b0, dvd_next};
            end
            S_ACC:
            begin
                if (k_reg[0])
                    sum_reg <= sum_reg - signed'(35'(t_reg));
                else
                    sum_reg <= sum_reg + signed'(35'(t_reg));
                k_reg  <= k_reg + 5'd1;
                sq_reg <= '0;
            end
            S_SQ:
            begin
                e_reg  <= prod[63:32];
                sq_reg <= sq_reg + 2'd1;
            end
            S_RND:
                act_reg <= rnd[32] ? '1 : rnd[31:16];
            default:
                ;
        endcase
        // the last series step hands the clamped sum to the squaring loop
        if (state_reg == S_ACC && k_reg == 5'(grbf_pkg::TERMS))
        begin
            if (k_reg[0])
                e_reg <= e_clamp;
            else
                e_reg <= (sum_reg + signed'(35'(t_reg)) < 0) ? '0 :
                         ((sum_reg + signed'(35'(t_reg))) > 35'sh0_FFFF_FFFF) ? '1 :
                         32'(sum_reg + signed'(35'(t_reg)));
        end
    end

    assign res.done = done_reg;
    assign res.act  = act_reg;

endmodule
